/* src/fqkr_pkg.sv */
// Package: shared types, command and status codes for the keyed-removal queue.
package fqkr_pkg;

   localparam int FQKR_DEPTH = 16;
   localparam int KEY_W = 16;
   localparam int HANDLE_W = 32;
   localparam int CMD_W = 2;
   localparam int STATUS_W = 2;
   localparam int ENTRY_COUNT_W = 5;

   localparam logic [CMD_W-1:0] CMD_ENQUEUE = 2'd0;
   localparam logic [CMD_W-1:0] CMD_DEQUEUE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;
   localparam logic [CMD_W-1:0] CMD_FIND = 2'd3;

   localparam logic [STATUS_W-1:0] STAT_OK = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 2'd2;
   localparam logic [STATUS_W-1:0] STAT_FULL = 2'd3;

   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic [HANDLE_W-1:0] handle;
   } slot_type;

   // Broadcast from the sequencer to every cell of the row.
   typedef struct packed {
      logic enq;
      logic del;
      logic search;
      logic [KEY_W-1:0] key;
      logic [HANDLE_W-1:0] handle;
   } cell_ctl_type;

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

endpackage

/* src/fqkr_cell.sv */
// One queue slot: holds an entry, matches the searched key and shifts towards the head.
module fqkr_cell
   import fqkr_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  cell_ctl_type ctl,
   input  logic prev_valid,
   input  logic prefix_in,
   input  logic upper_valid,
   input  slot_type upper_slot,
   output logic prefix_out,
   output logic hit,
   output logic valid_out,
   output slot_type slot_out,
   output logic valid_next,
   output slot_type slot_next
);

   logic valid_ff, valid_in;
   slot_type slot_ff, slot_in;
   logic match, load, shift;

   always_comb begin
      match = ctl.search && valid_ff && (slot_ff.handle != '0) && (slot_ff.key == ctl.key);
      prefix_out = prefix_in | match;
      hit = match & ~prefix_in;
      load = ctl.enq && !valid_ff && prev_valid;
      // Every slot from the removed entry upwards takes its younger neighbour.
      shift = ctl.del & prefix_out;
      slot_in = slot_ff;
      valid_in = valid_ff;
      if (shift) begin
         slot_in = upper_slot;
         valid_in = upper_valid;
      end else if (load) begin
         slot_in.key = ctl.key;
         slot_in.handle = ctl.handle;
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
   end

   assign valid_out = valid_ff;
   assign slot_out = slot_ff;
   assign valid_next = valid_in;
   assign slot_next = slot_in;

endmodule

/* src/fifo_queue_keyed_removal_core.sv */
// Top level: ordered process queue with removal by key, built as a row of slot cells.
//
// Requests arrive on the req_ stream: enqueue at the tail, dequeue the head,
// remove the oldest entry with a given key, or find that entry without
// removing it. Entries with a null (zero) handle never match a key.
// Each request gives exactly one response on the rsp_ stream with the status,
// the entry acted on, the handle now at the head and the entry count.
// A request is accepted in the idle state and executed in the execute state,
// so a new request is not accepted until the last one has executed. Keyed
// removal and search are carried out by the key match, which
// ripples a found flag along the row of cells and closes the gap in the same
// execute cycle. The response sits in an output register; the next request
// may be accepted while it waits, but is not executed until the response has
// been taken, so a stalled receiver holds back at most one request.
// Synchronous reset empties the queue (all slot valid flags cleared) and
// drops any pending request or response. Slot contents need no clearing.
module fifo_queue_keyed_removal_core
   import fqkr_pkg::*;
#(
   parameter int DEPTH = FQKR_DEPTH
)
(
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // command[1:0], key[17:2], handle[49:18], zero fill
   input  logic [55:0] req_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // status[1:0], result_handle[33:2], result_key[49:34], head_handle[81:50],
   // entry_count[86:82], zero fill
   output logic [87:0] rsp_tdata
);

   localparam int CW = $clog2(DEPTH + 1);
   localparam int RSP_BITS = STATUS_W + HANDLE_W + KEY_W + HANDLE_W + ENTRY_COUNT_W;

   state_type state_ff, state_in;
   logic [CMD_W-1:0] cmd_ff, cmd_in;
   logic [KEY_W-1:0] key_ff, key_in;
   logic [HANDLE_W-1:0] handle_ff, handle_in;
   logic [CW-1:0] count_ff, count_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [RSP_BITS-1:0] rsp_data_ff, rsp_data_in;

   logic req_fire, exec_fire;
   logic empty, full;
   cell_ctl_type ctl;

   logic [DEPTH:0] prefix;
   logic [DEPTH-1:0] hit, valid_v, valid_next_v;
   slot_type slot_v [DEPTH];
   slot_type slot_next_v [DEPTH];
   slot_type hit_slot;

   logic [STATUS_W-1:0] status;
   slot_type res_slot;
   logic [HANDLE_W-1:0] head_handle;

   assign empty = (count_ff == '0);
   assign full = (count_ff == CW'(DEPTH));
   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire = req_tvalid & req_tready;

   // Broadcast to the cells; state changes only when the execute cycle fires.
   always_comb begin
      ctl.enq = exec_fire && (cmd_ff == CMD_ENQUEUE) && !full;
      ctl.del = exec_fire && ((cmd_ff == CMD_DEQUEUE) || (cmd_ff == CMD_REMOVE));
      ctl.search = (cmd_ff == CMD_REMOVE) || (cmd_ff == CMD_FIND);
      ctl.key = key_ff;
      ctl.handle = handle_ff;
   end

   // A dequeue seeds the found flag at the head so the whole row shifts.
   assign prefix[0] = (cmd_ff == CMD_DEQUEUE) && !empty;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic prev_valid;
      logic upper_valid;
      slot_type upper_slot;
      if (i == 0) begin : g_head
         assign prev_valid = 1'b1;
      end else begin : g_body
         assign prev_valid = valid_v[i-1];
      end
      if (i == DEPTH - 1) begin : g_tail
         assign upper_valid = 1'b0;
         assign upper_slot = '0;
      end else begin : g_mid
         assign upper_valid = valid_v[i+1];
         assign upper_slot = slot_v[i+1];
      end
      fqkr_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .prev_valid (prev_valid),
         .prefix_in  (prefix[i]),
         .upper_valid(upper_valid),
         .upper_slot (upper_slot),
         .prefix_out (prefix[i+1]),
         .hit        (hit[i]),
         .valid_out  (valid_v[i]),
         .slot_out   (slot_v[i]),
         .valid_next (valid_next_v[i]),
         .slot_next  (slot_next_v[i])
      );
   end

   // At most one cell reports the first match, so the selection is an AND-OR.
   always_comb begin
      hit_slot = '0;
      for (int i = 0; i < DEPTH; i++) begin
         hit_slot = hit_slot | (hit[i] ? slot_v[i] : '0);
      end
   end

   always_comb begin
      status = STAT_OK;
      res_slot = '0;
      count_in = count_ff;
      unique case (cmd_ff)
         CMD_ENQUEUE: begin
            if (full) begin
               status = STAT_FULL;
            end else begin
               res_slot.key = key_ff;
               res_slot.handle = handle_ff;
               count_in = count_ff + CW'(1);
            end
         end
         CMD_DEQUEUE: begin
            if (empty) begin
               status = STAT_EMPTY;
            end else begin
               res_slot = slot_v[0];
               count_in = count_ff - CW'(1);
            end
         end
         default: begin
            if (empty) begin
               status = STAT_EMPTY;
            end else if (!prefix[DEPTH]) begin
               status = STAT_NOT_FOUND;
            end else begin
               res_slot = hit_slot;
               if (cmd_ff == CMD_REMOVE) begin
                  count_in = count_ff - CW'(1);
               end
            end
         end
      endcase
      head_handle = valid_next_v[0] ? slot_next_v[0].handle : '0;
      rsp_data_in = {ENTRY_COUNT_W'(count_in), head_handle, res_slot.key,
                     res_slot.handle, status};
   end

   // Sequencer: accept in idle, execute once the output register is free.
   always_comb begin
      state_in = state_ff;
      cmd_in = cmd_ff;
      key_in = key_ff;
      handle_in = handle_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      exec_fire = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               cmd_in = req_tdata[1:0];
               key_in = req_tdata[17:2];
               handle_in = req_tdata[49:18];
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (!rsp_valid_ff || rsp_tready) begin
               exec_fire = 1'b1;
               rsp_valid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (exec_fire) begin
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      key_ff <= key_in;
      handle_ff <= handle_in;
      if (exec_fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {{(88 - RSP_BITS){1'b0}}, rsp_data_ff};

endmodule
